/* hdl/ille_pkg.sv */
`timescale 1ns / 1ps

package ille_pkg;

  // Default table geometry.
  localparam int SLOTS_DEF      = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Request codes.
  typedef enum logic [2:0] {
    OP_INSERT_BEFORE = 3'd0,
    OP_PUSH_FRONT    = 3'd1,
    OP_PUSH_BACK     = 3'd2,
    OP_DELETE        = 3'd3,
    OP_POP_FRONT     = 3'd4,
    OP_POP_BACK      = 3'd5,
    OP_READ_SLOT     = 3'd6,
    OP_WALK          = 3'd7
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_T,
    S_INS_N,
    S_INS_P,
    S_INS_W,
    S_DEL_T,
    S_DEL_P,
    S_DEL_N,
    S_FETCH
  } state_t;

endpackage

/* hdl/ille_ram.sv */
`timescale 1ns / 1ps

module ille_ram #(
  parameter int DEPTH = ille_pkg::SLOTS_DEF,
  parameter int WIDTH = ille_pkg::VALUE_BITS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/ille_ctrl.sv */
`timescale 1ns / 1ps

module ille_ctrl #(
  parameter int SLOTS      = ille_pkg::SLOTS_DEF,
  parameter int VALUE_BITS = ille_pkg::VALUE_BITS_DEF,
  localparam int LW        = $clog2(SLOTS),
  localparam int NW        = 2 * LW + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_operation,
  input  logic [LW-1:0]         in_slot,
  input  logic [VALUE_BITS-1:0] in_item_value,
  // Node table port.
  output logic                  nm_we,
  output logic [LW-1:0]         nm_waddr,
  output logic [NW-1:0]         nm_wdata,
  output logic [LW-1:0]         mem_raddr,
  input  logic [NW-1:0]         nm_rdata,
  // Value table port.
  output logic                  vm_we,
  output logic [LW-1:0]         vm_waddr,
  output logic [VALUE_BITS-1:0] vm_wdata,
  input  logic [VALUE_BITS-1:0] vm_rdata,
  // Result beat.
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [LW-1:0]         out_node_slot,
  output logic [VALUE_BITS-1:0] out_node_value,
  output logic [LW-1:0]         out_node_next,
  output logic [LW-1:0]         out_node_prev,
  output logic                  out_node_is_free,
  output logic [LW-1:0]         out_list_size,
  output logic [LW-1:0]         out_front_slot,
  output logic [LW-1:0]         out_back_slot
);

  localparam logic [LW:0]   SLOTS_W = (LW+1)'(SLOTS);
  localparam logic [LW-1:0] LAST_IX = LW'(SLOTS - 1);
  localparam logic [LW-1:0] ZERO    = '0;
  localparam logic [LW-1:0] ONE     = LW'(1);

  ille_pkg::state_t state_r, state_nxt;

  logic [LW-1:0]         tgt_r, tgt_nxt;
  logic [LW-1:0]         new_r, new_nxt;
  logic [LW-1:0]         prev_r, prev_nxt;
  logic [LW-1:0]         nxt_r, nxt_nxt;
  logic [NW-1:0]         wt_r, wt_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [LW-1:0]         cnt_r, cnt_nxt;
  logic                  rd0_r;
  logic [LW-1:0]         free_head_r, free_head_nxt;
  logic [LW-1:0]         count_r, count_nxt;
  logic [LW-1:0]         first_r, first_nxt;
  logic [LW-1:0]         last_r, last_nxt;

  // Result staging.
  logic                  fin;
  logic [1:0]            fin_status;
  logic [LW-1:0]         fin_slot;
  logic [VALUE_BITS-1:0] fin_value;
  logic [LW-1:0]         fin_next;
  logic [LW-1:0]         fin_prev;
  logic                  fin_free;

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [LW-1:0]         out_slot_r, out_next_r, out_prev_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic                  out_free_r;
  logic [LW-1:0]         out_size_r, out_front_r, out_back_r;

  // The sentinel entry is always seen through the end registers.
  logic [NW-1:0] rd_word;
  logic          rd_free;
  logic [LW-1:0] rd_prev, rd_next;
  logic [NW-1:0] sent_word;
  logic [NW-1:0] wt_sel;
  logic          oob;
  logic          full;
  logic [LW-1:0] pick;

  assign sent_word = {1'b0, last_r, first_r};
  assign rd_word   = rd0_r ? sent_word : nm_rdata;
  assign rd_free   = rd_word[2*LW];
  assign rd_prev   = rd_word[2*LW-1:LW];
  assign rd_next   = rd_word[LW-1:0];
  assign oob       = ({1'b0, in_slot} >= SLOTS_W);
  assign full      = (({1'b0, count_r} + (LW+1)'(1)) >= SLOTS_W) || (free_head_r == ZERO);

  // State and bookkeeping registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ille_pkg::S_CLEAR;
      cnt_r       <= '0;
      free_head_r <= ONE;
      count_r     <= '0;
      first_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      free_head_r <= free_head_nxt;
      count_r     <= count_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      out_valid_r <= fin;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    tgt_r  <= tgt_nxt;
    new_r  <= new_nxt;
    prev_r <= prev_nxt;
    nxt_r  <= nxt_nxt;
    wt_r   <= wt_nxt;
    val_r  <= val_nxt;
    rd0_r  <= (mem_raddr == ZERO);
    if (fin) begin
      out_status_r <= fin_status;
      out_slot_r   <= fin_slot;
      out_value_r  <= fin_value;
      out_next_r   <= fin_next;
      out_prev_r   <= fin_prev;
      out_free_r   <= fin_free;
      out_size_r   <= count_nxt;
      out_front_r  <= first_nxt;
      out_back_r   <= last_nxt;
    end
  end

  // Sequencer: next state, memory accesses and result.
  always_comb begin
    state_nxt     = state_r;
    tgt_nxt       = tgt_r;
    new_nxt       = new_r;
    prev_nxt      = prev_r;
    nxt_nxt       = nxt_r;
    wt_nxt        = wt_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    free_head_nxt = free_head_r;
    count_nxt     = count_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    nm_we         = 1'b0;
    nm_waddr      = '0;
    nm_wdata      = '0;
    mem_raddr     = '0;
    vm_we         = 1'b0;
    vm_waddr      = '0;
    vm_wdata      = '0;
    fin           = 1'b0;
    fin_status    = ille_pkg::ST_OK;
    fin_slot      = '0;
    fin_value     = '0;
    fin_next      = '0;
    fin_prev      = '0;
    fin_free      = 1'b0;
    wt_sel        = '0;
    pick          = '0;

    unique case (state_r)
      ille_pkg::S_CLEAR: begin
        // Load the reset links, one entry a cycle.
        nm_we    = 1'b1;
        nm_waddr = cnt_r;
        nm_wdata = {(cnt_r != ZERO), ZERO,
                    ((cnt_r != ZERO) && (cnt_r != LAST_IX)) ? cnt_r + ONE : ZERO};
        cnt_nxt  = cnt_r + ONE;
        if (cnt_r == LAST_IX) begin
          state_nxt = ille_pkg::S_IDLE;
        end
      end

      ille_pkg::S_IDLE: begin
        if (start) begin
          val_nxt = in_item_value;
          unique case (in_operation) inside
            ille_pkg::OP_INSERT_BEFORE, ille_pkg::OP_PUSH_FRONT,
            ille_pkg::OP_PUSH_BACK: begin
              if (in_operation == ille_pkg::OP_INSERT_BEFORE) begin
                pick = in_slot;
              end else if (in_operation == ille_pkg::OP_PUSH_FRONT) begin
                pick = first_r;
              end
              if ((in_operation == ille_pkg::OP_INSERT_BEFORE) && oob) begin
                fin        = 1'b1;
                fin_status = ille_pkg::ST_RANGE;
              end else if (full) begin
                fin        = 1'b1;
                fin_status = ille_pkg::ST_FULL;
              end else begin
                tgt_nxt   = pick;
                mem_raddr = pick;
                state_nxt = ille_pkg::S_INS_T;
              end
            end
            ille_pkg::OP_DELETE, ille_pkg::OP_POP_FRONT, ille_pkg::OP_POP_BACK: begin
              if (in_operation == ille_pkg::OP_DELETE) begin
                pick = in_slot;
              end else if (in_operation == ille_pkg::OP_POP_FRONT) begin
                pick = first_r;
              end else begin
                pick = last_r;
              end
              if ((in_operation == ille_pkg::OP_DELETE) && oob) begin
                fin        = 1'b1;
                fin_status = ille_pkg::ST_RANGE;
              end else if ((count_r == ZERO) || (pick == ZERO)) begin
                fin        = 1'b1;
                fin_status = ille_pkg::ST_EMPTY;
              end else begin
                tgt_nxt   = pick;
                mem_raddr = pick;
                state_nxt = ille_pkg::S_DEL_T;
              end
            end
            ille_pkg::OP_READ_SLOT: begin
              if (oob) begin
                fin        = 1'b1;
                fin_status = ille_pkg::ST_RANGE;
              end else begin
                tgt_nxt   = in_slot;
                mem_raddr = in_slot;
                cnt_nxt   = '0;
                state_nxt = ille_pkg::S_FETCH;
              end
            end
            default: begin
              // Walk: start at the front, step count in the slot field.
              tgt_nxt   = first_r;
              mem_raddr = first_r;
              cnt_nxt   = in_slot;
              state_nxt = ille_pkg::S_FETCH;
            end
          endcase
        end
      end

      ille_pkg::S_INS_T: begin
        // A free target means append, that is insert before the sentinel.
        wt_sel    = rd_free ? sent_word : rd_word;
        tgt_nxt   = rd_free ? ZERO : tgt_r;
        wt_nxt    = wt_sel;
        prev_nxt  = wt_sel[2*LW-1:LW];
        mem_raddr = free_head_r;
        new_nxt   = free_head_r;
        state_nxt = ille_pkg::S_INS_N;
      end

      ille_pkg::S_INS_N: begin
        // Take the head of the free chain and fill in the new node.
        free_head_nxt = rd_next;
        nm_we         = 1'b1;
        nm_waddr      = new_r;
        nm_wdata      = {1'b0, prev_r, tgt_r};
        vm_we         = 1'b1;
        vm_waddr      = new_r;
        vm_wdata      = val_r;
        mem_raddr     = prev_r;
        state_nxt     = ille_pkg::S_INS_P;
      end

      ille_pkg::S_INS_P: begin
        nm_we    = 1'b1;
        nm_waddr = prev_r;
        if (prev_r == tgt_r) begin
          nm_wdata = {rd_free, new_r, new_r};
          fin      = 1'b1;
        end else begin
          nm_wdata  = {rd_free, rd_prev, new_r};
          state_nxt = ille_pkg::S_INS_W;
        end
      end

      ille_pkg::S_INS_W: begin
        nm_we    = 1'b1;
        nm_waddr = tgt_r;
        nm_wdata = {wt_r[2*LW], new_r, wt_r[LW-1:0]};
        fin      = 1'b1;
      end

      ille_pkg::S_DEL_T: begin
        if (rd_free) begin
          fin        = 1'b1;
          fin_status = ille_pkg::ST_EMPTY;
          state_nxt  = ille_pkg::S_IDLE;
        end else begin
          // Put the node on the free chain and look up its predecessor.
          nxt_nxt       = rd_next;
          prev_nxt      = rd_prev;
          val_nxt       = vm_rdata;
          new_nxt       = free_head_r;
          nm_we         = 1'b1;
          nm_waddr      = tgt_r;
          nm_wdata      = {1'b1, ZERO, free_head_r};
          free_head_nxt = tgt_r;
          mem_raddr     = rd_prev;
          state_nxt     = ille_pkg::S_DEL_P;
        end
      end

      ille_pkg::S_DEL_P: begin
        nm_we    = 1'b1;
        nm_waddr = prev_r;
        if (prev_r == nxt_r) begin
          nm_wdata = {rd_free, prev_r, nxt_r};
          fin      = 1'b1;
        end else begin
          nm_wdata  = {rd_free, rd_prev, nxt_r};
          mem_raddr = nxt_r;
          state_nxt = ille_pkg::S_DEL_N;
        end
      end

      ille_pkg::S_DEL_N: begin
        nm_we    = 1'b1;
        nm_waddr = nxt_r;
        nm_wdata = {rd_free, prev_r, rd_next};
        fin      = 1'b1;
      end

      ille_pkg::S_FETCH: begin
        if (cnt_r == ZERO) begin
          fin        = 1'b1;
          fin_slot   = tgt_r;
          fin_value  = (tgt_r == ZERO) ? '0 : vm_rdata;
          fin_next   = rd_next;
          fin_prev   = rd_prev;
          fin_free   = rd_free;
          state_nxt  = ille_pkg::S_IDLE;
        end else begin
          // One walk step per cycle along the next links.
          tgt_nxt   = rd_next;
          mem_raddr = rd_next;
          cnt_nxt   = cnt_r - ONE;
        end
      end

      default: begin
        state_nxt = ille_pkg::S_IDLE;
      end
    endcase

    // Completion of a successful insert or removal.
    if (fin && (state_r == ille_pkg::S_INS_P || state_r == ille_pkg::S_INS_W)) begin
      state_nxt = ille_pkg::S_IDLE;
      count_nxt = count_r + ONE;
      first_nxt = (prev_r == ZERO) ? new_r : first_r;
      last_nxt  = (tgt_r == ZERO) ? new_r : last_r;
      fin_slot  = new_r;
      fin_value = val_r;
      fin_next  = tgt_r;
      fin_prev  = prev_r;
      fin_free  = 1'b0;
    end
    if (fin && (state_r == ille_pkg::S_DEL_P || state_r == ille_pkg::S_DEL_N)) begin
      state_nxt = ille_pkg::S_IDLE;
      count_nxt = count_r - ONE;
      first_nxt = (prev_r == ZERO) ? nxt_r : first_r;
      last_nxt  = (nxt_r == ZERO) ? prev_r : last_r;
      fin_slot  = tgt_r;
      fin_value = val_r;
      fin_next  = new_r;
      fin_prev  = ZERO;
      fin_free  = 1'b1;
    end
  end

  assign busy             = (state_r != ille_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_node_slot    = out_slot_r;
  assign out_node_value   = out_value_r;
  assign out_node_next    = out_next_r;
  assign out_node_prev    = out_prev_r;
  assign out_node_is_free = out_free_r;
  assign out_list_size    = out_size_r;
  assign out_front_slot   = out_front_r;
  assign out_back_slot    = out_back_r;

endmodule

/* hdl/index_linked_list_engine_unit.sv */
`timescale 1ns / 1ps

// Doubly linked list engine over a table of SLOTS nodes; slot 0 is the
// sentinel. A request is taken when start is high and busy is low, and its
// result appears in the cycle after the last step, on the out_ ports for
// exactly one cycle with out_valid high; the receiver cannot stall, so
// capture it then. All links live in a node table with one write port and a
// registered read port, so each request takes one step per dependent table
// read. After reset the engine loads the free chain into the node table,
// entry by entry, with busy high.
module index_linked_list_engine_unit #(
  parameter int SLOTS      = ille_pkg::SLOTS_DEF,
  parameter int VALUE_BITS = ille_pkg::VALUE_BITS_DEF,
  localparam int LW        = $clog2(SLOTS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_operation,
  input  logic [LW-1:0]         in_slot,
  input  logic [VALUE_BITS-1:0] in_item_value,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [LW-1:0]         out_node_slot,
  output logic [VALUE_BITS-1:0] out_node_value,
  output logic [LW-1:0]         out_node_next,
  output logic [LW-1:0]         out_node_prev,
  output logic                  out_node_is_free,
  output logic [LW-1:0]         out_list_size,
  output logic [LW-1:0]         out_front_slot,
  output logic [LW-1:0]         out_back_slot
);

  localparam int NW = 2 * LW + 1;

  logic                  nm_we;
  logic [LW-1:0]         nm_waddr;
  logic [NW-1:0]         nm_wdata;
  logic [LW-1:0]         mem_raddr;
  logic [NW-1:0]         nm_rdata;
  logic                  vm_we;
  logic [LW-1:0]         vm_waddr;
  logic [VALUE_BITS-1:0] vm_wdata;
  logic [VALUE_BITS-1:0] vm_rdata;

  // Request sequencer and list bookkeeping.
  ille_ctrl #(
    .SLOTS      (SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_slot          (in_slot),
    .in_item_value    (in_item_value),
    .nm_we            (nm_we),
    .nm_waddr         (nm_waddr),
    .nm_wdata         (nm_wdata),
    .mem_raddr        (mem_raddr),
    .nm_rdata         (nm_rdata),
    .vm_we            (vm_we),
    .vm_waddr         (vm_waddr),
    .vm_wdata         (vm_wdata),
    .vm_rdata         (vm_rdata),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_node_slot    (out_node_slot),
    .out_node_value   (out_node_value),
    .out_node_next    (out_node_next),
    .out_node_prev    (out_node_prev),
    .out_node_is_free (out_node_is_free),
    .out_list_size    (out_list_size),
    .out_front_slot   (out_front_slot),
    .out_back_slot    (out_back_slot)
  );

  // Node table: free mark, prev link and next link per slot.
  ille_ram #(
    .DEPTH (SLOTS),
    .WIDTH (NW)
  ) u_node_mem (
    .clk   (clk),
    .we    (nm_we),
    .waddr (nm_waddr),
    .wdata (nm_wdata),
    .raddr (mem_raddr),
    .rdata (nm_rdata)
  );

  // Value table, read at the same slot as the node table.
  ille_ram #(
    .DEPTH (SLOTS),
    .WIDTH (VALUE_BITS)
  ) u_value_mem (
    .clk   (clk),
    .we    (vm_we),
    .waddr (vm_waddr),
    .wdata (vm_wdata),
    .raddr (mem_raddr),
    .rdata (vm_rdata)
  );

endmodule
